// ----- hw/rtl/rpsmc_pkg.sv -----
`default_nettype none

package rpsmc_pkg;

   // lattice geometry default
   localparam int SIDE_DEFAULT = 256;

   // field and datapath widths
   localparam int CELL_W     = 2;
   localparam int COORD_W    = 8;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 3;
   localparam int RNG_W      = 31;
   localparam int WGT_W      = 24;
   localparam int OPD_W      = 26;
   localparam int MUL_W      = RNG_W + OPD_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USED_W = CELL_W + 4 * COORD_W;
   localparam int REQ_PAD_W  = REQ_DATA_W - 2 * COORD_W - CELL_W;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // park-miller generator constants
   localparam logic [RNG_W-1:0] PM_MOD = 31'h7FFF_FFFF;
   localparam logic [OPD_W-1:0] PM_MUL = 26'd16807;

   // register reset values
   localparam logic [RNG_W-1:0] RESET_SEED = 31'd1;
   localparam logic [WGT_W-1:0] RESET_WP   = 24'd65536;
   localparam logic [WGT_W-1:0] RESET_WR   = 24'd65536;
   localparam logic [WGT_W-1:0] RESET_WX   = 24'd85899;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RNG_SEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_W_PRED   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_W_REPR   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_W_EXCH   = 2'd3;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;

   // cell contents
   localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;
   localparam logic [CELL_W-1:0] CELL_SP1   = 2'd1;
   localparam logic [CELL_W-1:0] CELL_SP2   = 2'd2;
   localparam logic [CELL_W-1:0] CELL_SP3   = 2'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCESS     = 3'd0,
      KIND_EMPTY_SITE = 3'd1,
      KIND_PREDATION  = 3'd2,
      KIND_REPRO      = 3'd3,
      KIND_EXCHANGE   = 3'd4,
      KIND_NO_CHANGE  = 3'd5
   } kind_type;

   // what the current random draw is for
   typedef enum logic [1:0] {
      DRAW_ROW = 2'd0,
      DRAW_COL = 2'd1,
      DRAW_DIR = 2'd2,
      DRAW_EVT = 2'd3
   } draw_type;

   // neighbour directions
   typedef enum logic [1:0] {
      DIR_ROW_INC = 2'd0,
      DIR_COL_INC = 2'd1,
      DIR_ROW_DEC = 2'd2,
      DIR_COL_DEC = 2'd3
   } dir_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_DRAW_MUL,
      ST_DRAW_RED,
      ST_DRAW_SCALE,
      ST_DRAW_TAKE,
      ST_SITE_RD,
      ST_SITE_CHK,
      ST_PART_RD,
      ST_PART_CAP,
      ST_WR_PART,
      ST_WR_SITE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     clr_wr;
      logic     take_req;
      logic     acc_go;
      logic     rng_mul;
      logic     rng_red;
      logic     scl_mul;
      logic     scl_take;
      logic     site_rd;
      logic     u1_cap;
      logic     part_rd;
      logic     u2_cap;
      logic     part_wr;
      logic     site_wr;
      logic     res_load;
      draw_type purpose;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     clr_last;
      logic     site_empty;
      logic     dir_ok;
      logic     out_free;
      kind_type kind;
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rpsmc_ram.sv -----
`default_nettype none

module rpsmc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rpsmc_ctrl.sv -----
`default_nettype none

module rpsmc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic [rpsmc_pkg::OP_W-1:0]   req_op,
   output logic                         req_tready,
   input  rpsmc_pkg::status_type        status,
   output rpsmc_pkg::cmd_type           cmd
);

   import rpsmc_pkg::*;

   state_type state_ff, state_in;
   draw_type  purpose_ff, purpose_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         purpose_ff <= DRAW_ROW;
      end else begin
         state_ff   <= state_in;
         purpose_ff <= purpose_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      purpose_in = purpose_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_MOVE) begin
                  state_in   = ST_DRAW_MUL;
                  purpose_in = DRAW_ROW;
               end else begin
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS:     state_in = ST_DONE;
         ST_DRAW_MUL:   state_in = ST_DRAW_RED;
         ST_DRAW_RED:   state_in = ST_DRAW_SCALE;
         ST_DRAW_SCALE: state_in = ST_DRAW_TAKE;
         ST_DRAW_TAKE: begin
            case (purpose_ff)
               DRAW_ROW: begin
                  state_in   = ST_DRAW_MUL;
                  purpose_in = DRAW_COL;
               end
               DRAW_COL: state_in = ST_SITE_RD;
               DRAW_DIR: state_in = status.dir_ok ? ST_PART_RD : ST_DRAW_MUL;
               DRAW_EVT: state_in = ST_WR_PART;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_SITE_RD: state_in = ST_SITE_CHK;
         ST_SITE_CHK: begin
            if (status.site_empty) begin
               state_in = ST_DONE;
            end else begin
               state_in   = ST_DRAW_MUL;
               purpose_in = DRAW_DIR;
            end
         end
         ST_PART_RD: state_in = ST_PART_CAP;
         ST_PART_CAP: begin
            state_in   = ST_DRAW_MUL;
            purpose_in = DRAW_EVT;
         end
         ST_WR_PART: begin
            state_in = (status.kind == KIND_EXCHANGE) ? ST_WR_SITE : ST_DONE;
         end
         ST_WR_SITE: state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd         = '0;
      cmd.purpose = purpose_ff;
      req_tready  = (state_ff == ST_IDLE);
      case (state_ff)
         ST_CLEAR:      cmd.clr_wr   = 1'b1;
         ST_IDLE:       cmd.take_req = req_tvalid;
         ST_ACCESS:     cmd.acc_go   = 1'b1;
         ST_DRAW_MUL:   cmd.rng_mul  = 1'b1;
         ST_DRAW_RED:   cmd.rng_red  = 1'b1;
         ST_DRAW_SCALE: cmd.scl_mul  = 1'b1;
         ST_DRAW_TAKE:  cmd.scl_take = 1'b1;
         ST_SITE_RD:    cmd.site_rd  = 1'b1;
         ST_SITE_CHK:   cmd.u1_cap   = 1'b1;
         ST_PART_RD:    cmd.part_rd  = 1'b1;
         ST_PART_CAP:   cmd.u2_cap   = 1'b1;
         ST_WR_PART: begin
            cmd.part_wr = status.kind inside {KIND_PREDATION, KIND_REPRO, KIND_EXCHANGE};
         end
         ST_WR_SITE:    cmd.site_wr  = 1'b1;
         ST_DONE:       cmd.res_load = status.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/rpsmc_dp.sv -----
`default_nettype none

module rpsmc_dp #(
   parameter int SIDE = rpsmc_pkg::SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rpsmc_pkg::cmd_type                 cmd,
   output rpsmc_pkg::status_type              status,
   input  logic [rpsmc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rpsmc_pkg::OP_W-1:0]         req_tuser,
   input  logic                               csr_wr_en,
   input  logic [rpsmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpsmc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [rpsmc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [rpsmc_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                               mem_wr_en,
   output logic [$clog2(SIDE*SIDE)-1:0]       mem_wr_addr,
   output logic [rpsmc_pkg::CELL_W-1:0]       mem_wr_data,
   output logic                               mem_rd_en,
   output logic [$clog2(SIDE*SIDE)-1:0]       mem_rd_addr,
   input  logic [rpsmc_pkg::CELL_W-1:0]       mem_rd_data
);

   import rpsmc_pkg::*;

   localparam int CW    = $clog2(SIDE);
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);

   // control and configuration state
   logic [RNG_W-1:0]  z_ff, z_in;
   logic [WGT_W-1:0]  w_pred_ff, w_pred_in;
   logic [WGT_W-1:0]  w_repr_ff, w_repr_in;
   logic [WGT_W-1:0]  w_exch_ff, w_exch_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [OP_W-1:0]        op_ff, op_in;
   logic [COORD_W-1:0]     row_ff, row_in;
   logic [COORD_W-1:0]     col_ff, col_in;
   logic [CELL_W-1:0]      val_ff, val_in;
   logic [MUL_W-1:0]       mul_ff, mul_in;
   logic [CW-1:0]          sr_ff, sr_in;
   logic [CW-1:0]          sc_ff, sc_in;
   logic [CW-1:0]          pr_ff, pr_in;
   logic [CW-1:0]          pc_ff, pc_in;
   logic [CELL_W-1:0]      u1_ff, u1_in;
   logic [CELL_W-1:0]      u2_ff, u2_in;
   kind_type               kind_ff, kind_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   kind_type               rsp_user_ff, rsp_user_in;

   // combinational values
   logic [OPD_W-1:0]    wsum;
   logic [OPD_W-1:0]    mul_opd;
   logic [MUL_W-1:0]    mul_prod;
   logic [RNG_W:0]      fold_sum;
   logic                fold_ge;
   logic [RNG_W-1:0]    rng_next;
   logic [OPD_W-1:0]    scaled;
   dir_type             dir;
   logic [CW:0]         side_ext;
   logic                dir_ok;
   logic [CW-1:0]       cand_pr;
   logic [CW-1:0]       cand_pc;
   logic [WGT_W:0]      w_pr_sum;
   logic [MUL_W-1:0]    thr_pred;
   logic [MUL_W-1:0]    thr_repr;
   logic                eats;
   kind_type            evt_kind;
   logic                acc_in_range;
   logic [AW-1:0]       acc_addr;
   logic [AW-1:0]       site_addr;
   logic [AW-1:0]       part_addr;
   logic [CELL_W-1:0]   res_cell;
   kind_type            res_kind;
   logic [COORD_W-1:0]  res_sr;
   logic [COORD_W-1:0]  res_sc;
   logic [COORD_W-1:0]  res_pr;
   logic [COORD_W-1:0]  res_pc;

   // species that the given species eats
   function automatic logic [CELL_W-1:0] prey_of(input logic [CELL_W-1:0] s);
      logic [CELL_W-1:0] p;
      case (s)
         CELL_SP1: p = CELL_SP2;
         CELL_SP2: p = CELL_SP3;
         CELL_SP3: p = CELL_SP1;
         default:  p = CELL_EMPTY;
      endcase
      return p;
   endfunction

   // shared multiplier: generator step or draw scaling
   always_comb begin
      wsum = OPD_W'(w_pred_ff) + OPD_W'(w_repr_ff) + OPD_W'(w_exch_ff);
      case (cmd.purpose)
         DRAW_ROW: mul_opd = OPD_W'(SIDE);
         DRAW_COL: mul_opd = OPD_W'(SIDE);
         DRAW_DIR: mul_opd = OPD_W'(4);
         DRAW_EVT: mul_opd = wsum;
         default:  mul_opd = '0;
      endcase
      if (cmd.rng_mul) mul_opd = PM_MUL;
      mul_prod = MUL_W'(z_ff) * MUL_W'(mul_opd);
   end

   // fold by 2^31-1: gives both x mod m and floor(x / m)
   always_comb begin
      fold_sum = (RNG_W+1)'(mul_ff[MUL_W-1:RNG_W]) + (RNG_W+1)'(mul_ff[RNG_W-1:0]);
      fold_ge  = fold_sum >= {1'b0, PM_MOD};
      rng_next = fold_ge ? RNG_W'(fold_sum - {1'b0, PM_MOD}) : fold_sum[RNG_W-1:0];
      scaled   = mul_ff[MUL_W-1:RNG_W] + OPD_W'(fold_ge);
   end

   // neighbour candidate and edge check
   always_comb begin
      dir      = dir_type'(scaled[1:0]);
      side_ext = (CW+1)'(SIDE);
      dir_ok   = 1'b0;
      cand_pr  = sr_ff;
      cand_pc  = sc_ff;
      case (dir)
         DIR_ROW_INC: begin
            dir_ok  = ((CW+1)'(sr_ff) + 1'b1) < side_ext;
            cand_pr = sr_ff + 1'b1;
         end
         DIR_COL_INC: begin
            dir_ok  = ((CW+1)'(sc_ff) + 1'b1) < side_ext;
            cand_pc = sc_ff + 1'b1;
         end
         DIR_ROW_DEC: begin
            dir_ok  = (sr_ff != '0);
            cand_pr = sr_ff - 1'b1;
         end
         DIR_COL_DEC: begin
            dir_ok  = (sc_ff != '0);
            cand_pc = sc_ff - 1'b1;
         end
         default: ;
      endcase
   end

   // event choice: compare z*W against weight*m thresholds
   always_comb begin
      w_pr_sum = (WGT_W+1)'(w_pred_ff) + (WGT_W+1)'(w_repr_ff);
      thr_pred = (MUL_W'(w_pred_ff) << RNG_W) - MUL_W'(w_pred_ff);
      thr_repr = (MUL_W'(w_pr_sum) << RNG_W) - MUL_W'(w_pr_sum);
      eats     = (u2_ff != CELL_EMPTY) && (u2_ff == prey_of(u1_ff));
      if (mul_ff <= thr_pred) begin
         evt_kind = eats ? KIND_PREDATION : KIND_NO_CHANGE;
      end else if (mul_ff <= thr_repr) begin
         evt_kind = (u2_ff == CELL_EMPTY) ? KIND_REPRO : KIND_NO_CHANGE;
      end else begin
         evt_kind = KIND_EXCHANGE;
      end
   end

   // lattice addresses
   always_comb begin
      acc_in_range = (32'(row_ff) < 32'(SIDE)) && (32'(col_ff) < 32'(SIDE));
      acc_addr     = AW'(32'(row_ff) * 32'(SIDE) + 32'(col_ff));
      site_addr    = AW'(32'(sr_ff) * 32'(SIDE) + 32'(sc_ff));
      part_addr    = AW'(32'(pr_ff) * 32'(SIDE) + 32'(pc_ff));
   end

   // memory port selection
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = CELL_EMPTY;
      if (cmd.clr_wr) begin
         mem_wr_en = 1'b1;
      end else if (cmd.acc_go && op_ff == OP_WRITE && acc_in_range) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = acc_addr;
         mem_wr_data = val_ff;
      end else if (cmd.part_wr) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = part_addr;
         mem_wr_data = (kind_ff == KIND_PREDATION) ? CELL_EMPTY : u1_ff;
      end else if (cmd.site_wr) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = site_addr;
         mem_wr_data = u2_ff;
      end

      mem_rd_en   = 1'b0;
      mem_rd_addr = site_addr;
      if (cmd.acc_go && op_ff == OP_READ && acc_in_range) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = acc_addr;
      end else if (cmd.site_rd) begin
         mem_rd_en = 1'b1;
      end else if (cmd.part_rd) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = part_addr;
      end
   end

   // result assembly
   always_comb begin
      res_cell = CELL_EMPTY;
      res_kind = KIND_ACCESS;
      res_sr   = '0;
      res_sc   = '0;
      res_pr   = '0;
      res_pc   = '0;
      case (op_ff)
         OP_WRITE: begin
            if (acc_in_range) res_cell = val_ff;
         end
         OP_READ: begin
            if (acc_in_range) res_cell = mem_rd_data;
         end
         OP_MOVE: begin
            res_cell = u1_ff;
            res_kind = kind_ff;
            res_sr   = COORD_W'(sr_ff);
            res_sc   = COORD_W'(sc_ff);
            if (kind_ff != KIND_EMPTY_SITE) begin
               res_pr = COORD_W'(pr_ff);
               res_pc = COORD_W'(pc_ff);
            end
         end
         default: ;
      endcase
   end

   // next values
   always_comb begin
      z_in      = z_ff;
      w_pred_in = w_pred_ff;
      w_repr_in = w_repr_ff;
      w_exch_in = w_exch_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RNG_SEED: z_in      = csr_wdata[RNG_W-1:0];
            CSR_W_PRED:   w_pred_in = csr_wdata[WGT_W-1:0];
            CSR_W_REPR:   w_repr_in = csr_wdata[WGT_W-1:0];
            CSR_W_EXCH:   w_exch_in = csr_wdata[WGT_W-1:0];
            default: ;
         endcase
      end else if (cmd.rng_red) begin
         z_in = rng_next;
      end

      clr_addr_in = cmd.clr_wr ? clr_addr_ff + 1'b1 : clr_addr_ff;

      op_in  = op_ff;
      row_in = row_ff;
      col_in = col_ff;
      val_in = val_ff;
      if (cmd.take_req) begin
         op_in  = req_tuser;
         row_in = req_tdata[COORD_W-1:0];
         col_in = req_tdata[2*COORD_W-1:COORD_W];
         val_in = req_tdata[2*COORD_W+CELL_W-1:2*COORD_W];
      end

      mul_in = (cmd.rng_mul || cmd.scl_mul) ? mul_prod : mul_ff;

      sr_in   = sr_ff;
      sc_in   = sc_ff;
      pr_in   = pr_ff;
      pc_in   = pc_ff;
      kind_in = kind_ff;
      if (cmd.scl_take) begin
         case (cmd.purpose)
            DRAW_ROW: sr_in = CW'(scaled);
            DRAW_COL: sc_in = CW'(scaled);
            DRAW_DIR: begin
               pr_in = cand_pr;
               pc_in = cand_pc;
            end
            DRAW_EVT: kind_in = evt_kind;
            default: ;
         endcase
      end

      u1_in = u1_ff;
      u2_in = u2_ff;
      if (cmd.u1_cap) begin
         u1_in = mem_rd_data;
         if (mem_rd_data == CELL_EMPTY) kind_in = KIND_EMPTY_SITE;
      end
      if (cmd.u2_cap) u2_in = mem_rd_data;

      // output register: loads while the old item is taken or absent
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (cmd.res_load) begin
         rsp_data_in = {{RSP_PAD_W{1'b0}}, res_pc, res_pr, res_sc, res_sr, res_cell};
         rsp_user_in = res_kind;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff         <= RESET_SEED;
         w_pred_ff    <= RESET_WP;
         w_repr_ff    <= RESET_WR;
         w_exch_ff    <= RESET_WX;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         z_ff         <= z_in;
         w_pred_ff    <= w_pred_in;
         w_repr_ff    <= w_repr_in;
         w_exch_ff    <= w_exch_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      mul_ff      <= mul_in;
      sr_ff       <= sr_in;
      sc_ff       <= sc_in;
      pr_ff       <= pr_in;
      pc_ff       <= pc_in;
      u1_ff       <= u1_in;
      u2_ff       <= u2_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // status to the controller
   always_comb begin
      status.clr_last   = (clr_addr_ff == AW'(DEPTH - 1));
      status.site_empty = (mem_rd_data == CELL_EMPTY);
      status.dir_ok     = dir_ok;
      status.out_free   = !rsp_valid_ff || rsp_tready;
      status.kind       = kind_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rps_lattice_monte_carlo_step.sv -----
// Access item (write, read, unused op): ACCESS, then DONE loads the output register when free.
// Move: row and column draws, SITE_RD and SITE_CHK for an empty site; a full move adds the
// direction draw, PART_RD, PART_CAP, event draw and WR_PART, an exchange also WR_SITE, and
// each redrawn neighbour another direction draw. A draw is generator multiply, fold, scaling
// multiply and take on the one shared 31x26 multiplier. One item at a time; the next is taken
// while the previous result waits. Reset clears all SIDE*SIDE cells (65536 at the default), taking no item.
`default_nettype none

module rps_lattice_monte_carlo_step #(
   parameter int SIDE = rpsmc_pkg::SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rpsmc_pkg::REQ_DATA_W-1:0]   req_tdata,  // row, col, cell_in
   input  logic [rpsmc_pkg::OP_W-1:0]         req_tuser,  // op
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rpsmc_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // cell_out, site_row, site_col,
                                                          // partner_row, partner_col
   output logic [rpsmc_pkg::KIND_W-1:0]       rsp_tuser,  // event_kind
   // configuration
   input  logic                               csr_wr_en,
   input  logic [rpsmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpsmc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import rpsmc_pkg::*;

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);

   cmd_type           cmd;
   status_type        status;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   // sequencer
   rpsmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // generator, scaling, event logic and output register
   rpsmc_dp #(
      .SIDE (SIDE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // lattice storage
   rpsmc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_lattice (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ----- tb/tb_rps_lattice_monte_carlo_step.sv -----
`timescale 1ns / 100ps

module tb_rps_lattice_monte_carlo_step;
   import rpsmc_pkg::*;

   localparam int LAT_SIDE      = SIDE_DEFAULT;
   localparam int QUIET_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 48;
   localparam int LONG_HOLD     = 300;
   localparam int N_DIRECTED    = 23;
   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 95;
   localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
   localparam logic [COORD_W-1:0] EDGE_HI = 8'(LAT_SIDE - 1);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [CELL_W-1:0]  cell_val;
   } lat_req_type;

   typedef struct packed {
      logic [CELL_W-1:0]  cell_out;
      kind_type           kind;
      logic [COORD_W-1:0] site_row;
      logic [COORD_W-1:0] site_col;
      logic [COORD_W-1:0] part_row;
      logic [COORD_W-1:0] part_col;
   } lat_rsp_type;

   typedef struct packed {
      lat_req_type       req;
      bit                typed;
      logic [CELL_W-1:0] exp_cell;
      kind_type          kind;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   bit [CELL_W-1:0] lat_cells [0:LAT_SIDE*LAT_SIDE-1];
   bit [RNG_W-1:0]  gen_state;
   bit [WGT_W-1:0]  w_pred, w_repr, w_exch;

   lat_rsp_type outcome_q [$];
   lat_rsp_type head_outcome;
   int       fail_count = 0;
   int       quiet_cycles = 0;
   bit       hold_rsp = 1'b0;
   bit       steady = 1'b0;
   int       burst_left = 0;

   rps_lattice_monte_carlo_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // row, col, cell_in
      .req_tuser  (req_tuser),   // op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // cell_out, site_row, site_col, partner_row, partner_col
      .rsp_tuser  (rsp_tuser),   // event_kind
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // park-miller step
   function automatic bit [RNG_W-1:0] pm_next(bit [RNG_W-1:0] z);
      longint unsigned p;
      p = longint'(z) * longint'(PM_MUL);
      return RNG_W'(p % longint'(PM_MOD));
   endfunction

   // floor(z * n / modulus)
   function automatic int unsigned scale_draw(bit [RNG_W-1:0] z, int unsigned n);
      return int'((longint'(z) * longint'(n)) / longint'(PM_MOD));
   endfunction

   // site and first direction that the next move would draw from state z0
   function automatic void peek_move(input bit [RNG_W-1:0] z0, output int unsigned sr,
                                     output int unsigned sc, output int unsigned d);
      bit [RNG_W-1:0] z;
      z  = pm_next(z0);
      sr = scale_draw(z, LAT_SIDE);
      z  = pm_next(z);
      sc = scale_draw(z, LAT_SIDE);
      z  = pm_next(z);
      d  = scale_draw(z, 4);
   endfunction

   // neighbour of a site, ok low when it lies off the lattice
   function automatic bit neighbour(input int unsigned sr, input int unsigned sc,
                                    input int unsigned d, output int unsigned pr,
                                    output int unsigned pc);
      pr = sr;
      pc = sc;
      case (dir_type'(d[1:0]))
         DIR_ROW_INC: begin
            if (sr + 1 >= LAT_SIDE) return 1'b0;
            pr = sr + 1;
         end
         DIR_COL_INC: begin
            if (sc + 1 >= LAT_SIDE) return 1'b0;
            pc = sc + 1;
         end
         DIR_ROW_DEC: begin
            if (sr == 0) return 1'b0;
            pr = sr - 1;
         end
         default: begin
            if (sc == 0) return 1'b0;
            pc = sc - 1;
         end
      endcase
      return 1'b1;
   endfunction

   // expected outcome of one accepted item, updates the lattice and generator copy
   function automatic lat_rsp_type lattice_step(lat_req_type it);
      lat_rsp_type r;
      int unsigned sr, sc, pr, pc, d;
      bit [CELL_W-1:0] u1, u2;
      longint unsigned wsum, lhs;
      bit ok;
      r = '0;
      r.kind = KIND_ACCESS;
      if (it.op == OP_WRITE || it.op == OP_READ) begin
         if (it.op == OP_WRITE) lat_cells[{it.row, it.col}] = it.cell_val;
         r.cell_out = lat_cells[{it.row, it.col}];
         return r;
      end
      if (it.op != OP_MOVE) return r;
      gen_state = pm_next(gen_state);
      sr = scale_draw(gen_state, LAT_SIDE);
      gen_state = pm_next(gen_state);
      sc = scale_draw(gen_state, LAT_SIDE);
      u1 = lat_cells[sr * LAT_SIDE + sc];
      r.cell_out = u1;
      r.site_row = 8'(sr);
      r.site_col = 8'(sc);
      if (u1 == CELL_EMPTY) begin
         r.kind = KIND_EMPTY_SITE;
         return r;
      end
      // redraw while the neighbour is off the lattice
      do begin
         gen_state = pm_next(gen_state);
         d  = scale_draw(gen_state, 4);
         ok = neighbour(sr, sc, d, pr, pc);
      end while (!ok);
      u2 = lat_cells[pr * LAT_SIDE + pc];
      gen_state = pm_next(gen_state);
      wsum = longint'(w_pred) + longint'(w_repr) + longint'(w_exch);
      lhs  = longint'(gen_state) * wsum;
      if (lhs <= longint'(w_pred) * longint'(PM_MOD)) begin
         if (u2 != CELL_EMPTY && int'(u2) == (int'(u1) % 3) + 1) begin
            lat_cells[pr * LAT_SIDE + pc] = CELL_EMPTY;
            r.kind = KIND_PREDATION;
         end else begin
            r.kind = KIND_NO_CHANGE;
         end
      end else if (lhs <= (longint'(w_pred) + longint'(w_repr)) * longint'(PM_MOD)) begin
         if (u2 == CELL_EMPTY) begin
            lat_cells[pr * LAT_SIDE + pc] = u1;
            r.kind = KIND_REPRO;
         end else begin
            r.kind = KIND_NO_CHANGE;
         end
      end else begin
         lat_cells[pr * LAT_SIDE + pc] = u1;
         lat_cells[sr * LAT_SIDE + sc] = u2;
         r.kind = KIND_EXCHANGE;
      end
      r.part_row = 8'(pr);
      r.part_col = 8'(pc);
      return r;
   endfunction

   // receiver: own stall pattern, plus one long hold on request
   initial begin : rx_side
      int rx_cycle;
      int rx_mode;
      rx_cycle = 0;
      rx_mode  = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rx_cycle++;
            if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= rx_cycle[2];
               default: rsp_tready <= ($urandom_range(0, 1) == 1);
            endcase
         end
      end
   end

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("result item with no outcome waiting");
            fail_count++;
         end else begin
            head_outcome = outcome_q.pop_front();
            check_field("cell_out", head_outcome.cell_out, rsp_tdata[1:0]);
            check_field("event_kind", head_outcome.kind, rsp_tuser);
            check_field("site_row", head_outcome.site_row, rsp_tdata[9:2]);
            check_field("site_col", head_outcome.site_col, rsp_tdata[17:10]);
            check_field("partner_row", head_outcome.part_row, rsp_tdata[25:18]);
            check_field("partner_col", head_outcome.part_col, rsp_tdata[33:26]);
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_rps_lattice_monte_carlo_step: done, errors");
            $finish;
         end
      end
   end

   // offer one item, hold until accepted, then predict
   task automatic send_item(lat_req_type it, bit typed, lat_rsp_type typed_exp);
      lat_rsp_type p;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, it.cell_val, it.col, it.row};
      req_tuser  <= it.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = lattice_step(it);
      outcome_q.push_back(typed ? typed_exp : p);
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // sender in bursts with random gaps
   task automatic pace_item(lat_req_type it, bit typed, lat_rsp_type typed_exp);
      if (burst_left == 0) begin
         if (!steady && $urandom_range(0, 1) == 1) pause_sender($urandom_range(1, 12));
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      send_item(it, typed, typed_exp);
   endtask

   // wait until every outcome has come and the block is quiet
   task automatic settle();
      pause_sender(1);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RNG_SEED: gen_state = val[RNG_W-1:0];
         CSR_W_PRED:   w_pred = val[WGT_W-1:0];
         CSR_W_REPR:   w_repr = val[WGT_W-1:0];
         default:      w_exch = val[WGT_W-1:0];
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // seed whose first move lands on the border and draws a neighbour off the lattice
   function automatic bit [RNG_W-1:0] border_seed();
      bit [RNG_W-1:0] s;
      int unsigned sr, sc, d, pr, pc;
      for (int tries = 0; tries < 200000; tries++) begin
         s = RNG_W'($urandom_range(1, 32'h7FFF_FFFE));
         peek_move(s, sr, sc, d);
         if (!neighbour(sr, sc, d, pr, pc)) return s;
      end
      return s;
   endfunction

   task automatic configure(int p);
      bit [RNG_W-1:0] s;
      bit [WGT_W-1:0] wp, wr, wx;
      s  = RNG_W'($urandom_range(1, 32'h7FFF_FFFE));
      wp = WGT_W'($urandom);
      wr = WGT_W'($urandom);
      wx = WGT_W'($urandom);
      steady = 1'b0;
      case (p)
         1: s = PM_MOD;
         2: s = '0;
         3: begin
            s = border_seed();
            wp = '0; wr = '0; wx = '0;
         end
         4: begin
            s = border_seed();
            wp = '0; wr = '0; wx = '1;
         end
         5: begin
            wp = '0; wr = '1; wx = '0;
         end
         6: begin
            s = PM_MOD - 1;
            wp = '1; wr = '1; wx = '1;
            steady = 1'b1;
         end
         7: begin
            wp = '1;
            wr = WGT_W'($urandom_range(0, 255));
         end
         default: ;
      endcase
      csr_write(CSR_RNG_SEED, s);
      csr_write(CSR_W_PRED, wp);
      csr_write(CSR_W_REPR, wr);
      csr_write(CSR_W_EXCH, wx);
   endtask

   // mostly a site and its neighbours set up ahead of the move that will pick it
   task automatic run_random_phase(int n_items);
      lat_req_type it;
      lat_rsp_type none;
      int unsigned sr, sc, d, pr, pc;
      int sent;
      bit first;
      none  = '0;
      sent  = 0;
      first = 1'b1;
      while (sent < n_items) begin
         if (first || $urandom_range(0, 9) < 7) begin
            peek_move(gen_state, sr, sc, d);
            it = '{OP_WRITE, 8'(sr), 8'(sc),
                   ($urandom_range(0, 9) == 0) ? CELL_EMPTY : 2'($urandom_range(1, 3))};
            pace_item(it, 1'b0, none);
            sent++;
            for (int k = 0; k < 4; k++) begin
               if (neighbour(sr, sc, k, pr, pc) && $urandom_range(0, 3) != 0) begin
                  it = '{OP_WRITE, 8'(pr), 8'(pc), 2'($urandom_range(0, 3))};
                  pace_item(it, 1'b0, none);
                  sent++;
               end
            end
            it = '{OP_MOVE, 8'($urandom), 8'($urandom), 2'($urandom)};
            pace_item(it, 1'b0, none);
            sent++;
         end else begin
            it = '{2'($urandom), 8'($urandom), 8'($urandom), 2'($urandom)};
            pace_item(it, 1'b0, none);
            sent++;
         end
         first = 1'b0;
      end
   endtask

   // directed items: border cells, unused op, bit patterns, then moves on prepared sites and read-backs
   dir_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{'{OP_READ,   8'd0,    8'd0,    CELL_EMPTY}, 1'b1, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_READ,   EDGE_HI, EDGE_HI, CELL_EMPTY}, 1'b1, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_WRITE,  EDGE_HI, EDGE_HI, CELL_SP3},   1'b1, CELL_SP3,   KIND_ACCESS},
      '{'{OP_READ,   EDGE_HI, EDGE_HI, CELL_EMPTY}, 1'b1, CELL_SP3,   KIND_ACCESS},
      '{'{OP_WRITE,  8'd0,    EDGE_HI, CELL_SP2},   1'b1, CELL_SP2,   KIND_ACCESS},
      '{'{OP_WRITE,  EDGE_HI, 8'd0,    CELL_SP1},   1'b1, CELL_SP1,   KIND_ACCESS},
      '{'{OP_READ,   8'd0,    EDGE_HI, CELL_SP3},   1'b1, CELL_SP2,   KIND_ACCESS},
      '{'{OP_UNUSED, EDGE_HI, EDGE_HI, CELL_SP3},   1'b1, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_WRITE,  8'd170,  8'd85,   CELL_SP2},   1'b1, CELL_SP2,   KIND_ACCESS},
      '{'{OP_READ,   8'd85,   8'd170,  CELL_EMPTY}, 1'b1, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_WRITE,  8'd170,  8'd85,   CELL_EMPTY}, 1'b1, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_WRITE,  8'd0,    8'd33,   CELL_SP1},   1'b1, CELL_SP1,   KIND_ACCESS},
      '{'{OP_WRITE,  8'd0,    8'd32,   CELL_EMPTY}, 1'b1, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_WRITE,  8'd136,  8'd56,   CELL_SP2},   1'b1, CELL_SP2,   KIND_ACCESS},
      '{'{OP_WRITE,  8'd137,  8'd56,   CELL_SP3},   1'b1, CELL_SP3,   KIND_ACCESS},
      '{'{OP_WRITE,  8'd173,  8'd239,  CELL_SP3},   1'b1, CELL_SP3,   KIND_ACCESS},
      '{'{OP_WRITE,  8'd173,  8'd240,  CELL_SP1},   1'b1, CELL_SP1,   KIND_ACCESS},
      '{'{OP_MOVE,   8'd0,    8'd0,    CELL_EMPTY}, 1'b0, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_MOVE,   EDGE_HI, EDGE_HI, CELL_SP3},   1'b0, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_MOVE,   8'd0,    8'd0,    CELL_EMPTY}, 1'b0, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_MOVE,   8'd0,    8'd0,    CELL_EMPTY}, 1'b0, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_READ,   8'd0,    8'd32,   CELL_EMPTY}, 1'b0, CELL_EMPTY, KIND_ACCESS},
      '{'{OP_READ,   8'd136,  8'd56,   CELL_EMPTY}, 1'b0, CELL_EMPTY, KIND_ACCESS}
   };

   // main sequence
   initial begin : stim
      lat_rsp_type typed_exp;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // predictor state after reset
      foreach (lat_cells[i]) lat_cells[i] = CELL_EMPTY;
      gen_state = RESET_SEED;
      w_pred = RESET_WP;
      w_repr = RESET_WR;
      w_exch = RESET_WX;

      foreach (directed_rows[i]) begin
         typed_exp = '0;
         typed_exp.cell_out = directed_rows[i].exp_cell;
         typed_exp.kind = directed_rows[i].kind;
         pace_item(directed_rows[i].req, directed_rows[i].typed, typed_exp);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         settle();
         configure(p);
         if (p == 0) hold_rsp = 1'b1;
         run_random_phase(PHASE_ITEMS);
      end

      settle();
      if (fail_count == 0) begin
         $display("tb_rps_lattice_monte_carlo_step: done, clean");
      end else begin
         $display("tb_rps_lattice_monte_carlo_step: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/rpsmc_pkg.sv
hw/rtl/rpsmc_ram.sv
hw/rtl/rpsmc_ctrl.sv
hw/rtl/rpsmc_dp.sv
hw/rtl/rps_lattice_monte_carlo_step.sv
tb/tb_rps_lattice_monte_carlo_step.sv
